// ===== hdl/int128_alu_top_macros.svh =====
// assertion helpers used by the int128 alu top
`ifndef INT128_ALU_TOP_MACROS_SVH
`define INT128_ALU_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define I128_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("int128_alu: same-cycle check failed");

// next-cycle implication, checked outside reset
`define I128_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("int128_alu: next-cycle check failed");

`endif

// ===== hdl/i128alu_pkg.sv =====
`default_nettype none
package i128alu_pkg;

    localparam int WORD_W = 64;
    localparam int LIMB_W = 32;
    localparam int QUAD_W = 2 * WORD_W;
    localparam int KIND_W = 4;
    localparam int SHAMT_W = $clog2(QUAD_W);

    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [QUAD_W-1:0] quad_t;
    typedef logic [KIND_W-1:0] kind_bits_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_NEG  = 4'd2,
        KIND_MUL  = 4'd3,
        KIND_AND  = 4'd4,
        KIND_OR   = 4'd5,
        KIND_XOR  = 4'd6,
        KIND_SHL  = 4'd7,
        KIND_SHR  = 4'd8,
        KIND_SAR  = 4'd9,
        KIND_SEXT = 4'd10
    } kind_t;

    // load enables of the two middle pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
    } pipe_en_t;

endpackage
`default_nettype wire

// ===== hdl/i128alu_ifs.sv =====
`default_nettype none
// operation request channel
interface i128alu_in_if;
    import i128alu_pkg::*;

    logic       valid;
    logic       ready;
    kind_bits_t kind;
    word_t      a_low;
    word_t      a_high;
    word_t      b_low;
    word_t      b_high;

    modport source (output valid, kind, a_low, a_high, b_low, b_high, input ready);
    modport sink (input valid, kind, a_low, a_high, b_low, b_high, output ready);
endinterface

// result channel
interface i128alu_out_if;
    import i128alu_pkg::*;

    logic  valid;
    logic  ready;
    word_t result_low;
    word_t result_high;

    modport source (output valid, result_low, result_high, input ready);
    modport sink (input valid, result_low, result_high, output ready);
endinterface
`default_nettype wire

// ===== hdl/i128alu_basic.sv =====
`default_nettype none
module i128alu_basic (
    input  wire i128alu_pkg::kind_bits_t kind,
    input  wire i128alu_pkg::quad_t      a,
    input  wire i128alu_pkg::quad_t      b,
    output i128alu_pkg::quad_t           result
);
    import i128alu_pkg::*;

    logic                 shift_big;
    logic [SHAMT_W-1:0]   shamt;
    quad_t                shl_val;
    quad_t                shr_val;
    quad_t                sar_val;

    // shift amount comes from the low word of b; 128 or more saturates
    assign shift_big = |b[WORD_W-1:SHAMT_W];
    assign shamt     = b[SHAMT_W-1:0];

    assign shl_val = shift_big ? '0 : (a << shamt);
    assign shr_val = shift_big ? '0 : (a >> shamt);
    assign sar_val = shift_big ? {QUAD_W{a[QUAD_W-1]}}
                               : quad_t'($signed(a) >>> shamt);

    // everything except the multiply, in one pass
    always_comb
    begin
        case (kind_t'(kind))
            KIND_ADD:  result = a + b;
            KIND_SUB:  result = a - b;
            KIND_NEG:  result = '0 - a;
            KIND_AND:  result = a & b;
            KIND_OR:   result = a | b;
            KIND_XOR:  result = a ^ b;
            KIND_SHL:  result = shl_val;
            KIND_SHR:  result = shr_val;
            KIND_SAR:  result = sar_val;
            KIND_SEXT: result = {{WORD_W{a[WORD_W-1]}}, a[WORD_W-1:0]};
            default:   result = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/i128alu_mul.sv =====
`default_nettype none
module i128alu_mul (
    input  wire                     clk,
    input  wire i128alu_pkg::quad_t a,
    input  wire i128alu_pkg::quad_t b,
    input  wire i128alu_pkg::pipe_en_t en,
    output i128alu_pkg::quad_t      lo_sum,
    output i128alu_pkg::word_t      hi_word
);
    import i128alu_pkg::*;

    limb_t a0, a1, a2, a3;
    limb_t b0, b1, b2, b3;

    word_t p00_reg, p01_reg, p10_reg, p02_reg, p11_reg, p20_reg;
    limb_t t03_reg, t12_reg, t21_reg, t30_reg;
    word_t p00_next, p01_next, p10_next, p02_next, p11_next, p20_next;
    word_t t03_full, t12_full, t21_full, t30_full;

    quad_t lo_sum_reg, lo_sum_next;
    word_t hi_word_reg, hi_word_next;
    word_t mid_sum;
    limb_t top_sum;

    function automatic word_t mul32(input limb_t x, input limb_t y);
        word_t r;
        r = word_t'(x) * word_t'(y);
        return r;
    endfunction

    assign {a3, a2, a1, a0} = a;
    assign {b3, b2, b1, b0} = b;

    // limb products that reach the low 128 bits
    assign p00_next = mul32(a0, b0);
    assign p01_next = mul32(a0, b1);
    assign p10_next = mul32(a1, b0);
    assign p02_next = mul32(a0, b2);
    assign p11_next = mul32(a1, b1);
    assign p20_next = mul32(a2, b0);
    assign t03_full = mul32(a0, b3);
    assign t12_full = mul32(a1, b2);
    assign t21_full = mul32(a2, b1);
    assign t30_full = mul32(a3, b0);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p02_reg <= p02_next;
            p11_reg <= p11_next;
            p20_reg <= p20_next;
            t03_reg <= t03_full[LIMB_W-1:0];
            t12_reg <= t12_full[LIMB_W-1:0];
            t21_reg <= t21_full[LIMB_W-1:0];
            t30_reg <= t30_full[LIMB_W-1:0];
        end
    end

    // column sums: low columns at full width, upper word modulo 2^64
    assign lo_sum_next = {{WORD_W{1'b0}}, p00_reg}
                       + {{LIMB_W{1'b0}}, p01_reg, {LIMB_W{1'b0}}}
                       + {{LIMB_W{1'b0}}, p10_reg, {LIMB_W{1'b0}}};
    assign mid_sum     = p02_reg + p11_reg + p20_reg;
    assign top_sum     = t03_reg + t12_reg + t21_reg + t30_reg;
    assign hi_word_next = mid_sum + {top_sum, {LIMB_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            lo_sum_reg  <= lo_sum_next;
            hi_word_reg <= hi_word_next;
        end
    end

    assign lo_sum  = lo_sum_reg;
    assign hi_word = hi_word_reg;
endmodule
`default_nettype wire

// ===== hdl/int128_alu_top.sv =====
`default_nettype none
// 128-bit integer alu: add, sub, neg, mul (low 128 bits), and, or, xor, shl, shr, sar and
// sign extension of the low word. One request is taken every cycle unless a stalled result
// holds the pipe, and one result comes out per request, in order. Every operation passes the
// input register and then the same stages: the multiply is built from 32x32 limb products,
// which take one register stage, their column sums a second and the final 128-bit add the
// third, and all other operations travel alongside it. Each stage moves on when the one after
// it is empty or moving, so a stalled result only holds the stages that are full behind it.
module int128_alu_top (
    input  wire          clk,
    input  wire          rst_n,
    i128alu_in_if.sink   req,
    i128alu_out_if.source rsp
);
    import i128alu_pkg::*;

    `include "int128_alu_top_macros.svh"

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic ld0, ld1, ld2, ld_out;
    pipe_en_t mul_en;

    kind_bits_t kind0_reg;
    quad_t      a0_reg, b0_reg;
    logic       mul1_reg, mul2_reg;
    quad_t      res1_reg, res2_reg, res1_next;
    quad_t      out_reg, out_next;
    quad_t      mul_lo_sum;
    word_t      mul_hi_word;

    // stage load enables, ripple back from the result register
    assign ld_out = !out_valid_reg || rsp.ready;
    assign ld2    = !s2_valid_reg || ld_out;
    assign ld1    = !s1_valid_reg || ld2;
    assign ld0    = !s0_valid_reg || ld1;
    assign req.ready = ld0;
    assign mul_en = '{s1: ld1, s2: ld2};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld0)
                s0_valid_reg <= req.valid;
            if (ld1)
                s1_valid_reg <= s0_valid_reg;
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            kind0_reg <= req.kind;
            a0_reg    <= {req.a_high, req.a_low};
            b0_reg    <= {req.b_high, req.b_low};
        end
    end

    i128alu_basic u_basic (
        .kind   (kind0_reg),
        .a      (a0_reg),
        .b      (b0_reg),
        .result (res1_next)
    );

    i128alu_mul u_mul (
        .clk     (clk),
        .a       (a0_reg),
        .b       (b0_reg),
        .en      (mul_en),
        .lo_sum  (mul_lo_sum),
        .hi_word (mul_hi_word)
    );

    // non-multiply results ride along with the product stages
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            mul1_reg <= (kind_t'(kind0_reg) == KIND_MUL);
            res1_reg <= res1_next;
        end
        if (ld2)
        begin
            mul2_reg <= mul1_reg;
            res2_reg <= res1_reg;
        end
    end

    // final product add and result select
    assign out_next = mul2_reg ? (mul_lo_sum + {mul_hi_word, {WORD_W{1'b0}}}) : res2_reg;

    always_ff @(posedge clk)
    begin
        if (ld_out)
            out_reg <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_low  = out_reg[WORD_W-1:0];
    assign rsp.result_high = out_reg[QUAD_W-1:WORD_W];

    // an empty input stage always takes a transfer
    `I128_ASSERT_IMP(a_empty_ready, clk, rst_n, !s0_valid_reg, req.ready)
    // a full stage behind a stalled result stays full
    `I128_ASSERT_NXT(a_s2_hold, clk, rst_n, s2_valid_reg && rsp.valid && !rsp.ready,
                     s2_valid_reg)
    // an item leaving the input stage lands in stage one
    `I128_ASSERT_NXT(a_s0_moves, clk, rst_n, s0_valid_reg && ld1, s1_valid_reg)
    // a transfer is never refused while the result is being taken
    `I128_ASSERT_IMP(a_flow, clk, rst_n, rsp.ready, req.ready)
endmodule
`default_nettype wire

// ===== dv/tb_int128_alu_top.sv =====
`default_nettype none
module tb_int128_alu_top;
    import i128alu_pkg::*;

    // opcodes outside the defined set
    localparam kind_bits_t KIND_UNDEF_LO = 4'd11;
    localparam kind_bits_t KIND_UNDEF_HI = 4'd15;

    // where the expected result of a table row comes from
    localparam bit EXP_GIVEN = 1'b1;
    localparam bit EXP_MODEL = 1'b0;

    localparam word_t W_ONES = '1;
    localparam word_t W_MSB  = 64'h8000_0000_0000_0000;
    localparam word_t W_MAXP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam word_t P1     = 64'h0123_4567_89AB_CDEF;
    localparam word_t P2     = 64'hFEDC_BA98_7654_3210;
    localparam word_t P3     = 64'hDEAD_BEEF_CAFE_F00D;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 650;
    localparam int HOLD_AT_XFER = 300;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        kind_bits_t kind;
        word_t      a_low;
        word_t      a_high;
        word_t      b_low;
        word_t      b_high;
        bit         given;
        word_t      want_low;
        word_t      want_high;
    } alu_row_t;

    // directed table: kind, a_low, a_high, b_low, b_high, source, low, high
    alu_row_t directed_rows [N_DIRECTED] = '{
        '{KIND_ADD,  0,      0,      0,      0,      EXP_GIVEN, 0,      0},
        '{KIND_ADD,  W_ONES, W_ONES, 1,      0,      EXP_GIVEN, 0,      0},
        '{KIND_ADD,  W_ONES, 0,      1,      0,      EXP_GIVEN, 0,      1},
        '{KIND_SUB,  0,      0,      1,      0,      EXP_GIVEN, W_ONES, W_ONES},
        '{KIND_SUB,  0,      1,      1,      0,      EXP_GIVEN, W_ONES, 0},
        '{KIND_NEG,  1,      0,      P1,     P2,     EXP_GIVEN, W_ONES, W_ONES},
        '{KIND_NEG,  0,      W_MSB,  W_ONES, W_ONES, EXP_GIVEN, 0,      W_MSB},
        '{KIND_MUL,  W_ONES, W_ONES, W_ONES, W_ONES, EXP_GIVEN, 1,      0},
        '{KIND_MUL,  W_ONES, 0,      W_ONES, 0,      EXP_GIVEN, 1,
          64'hFFFF_FFFF_FFFF_FFFE},
        '{KIND_MUL,  P1,     P2,     P3,     P1,     EXP_MODEL, 0,      0},
        '{KIND_AND,  P1,     P2,     W_ONES, 0,      EXP_GIVEN, P1,     0},
        '{KIND_OR,   P1,     P2,     P2,     P1,     EXP_GIVEN, W_ONES, W_ONES},
        '{KIND_XOR,  P3,     P2,     P3,     P2,     EXP_GIVEN, 0,      0},
        '{KIND_SHL,  P1,     P2,     0,      P3,     EXP_GIVEN, P1,     P2},
        '{KIND_SHL,  1,      0,      127,    0,      EXP_GIVEN, 0,      W_MSB},
        '{KIND_SHL,  P1,     P2,     64,     0,      EXP_GIVEN, 0,      P1},
        '{KIND_SHL,  P1,     P2,     32,     0,      EXP_MODEL, 0,      0},
        '{KIND_SHL,  W_ONES, W_ONES, 128,    0,      EXP_GIVEN, 0,      0},
        '{KIND_SHR,  W_ONES, W_ONES, 127,    0,      EXP_GIVEN, 1,      0},
        '{KIND_SHR,  W_ONES, W_ONES, W_ONES, 0,      EXP_GIVEN, 0,      0},
        '{KIND_SAR,  0,      W_MSB,  127,    0,      EXP_GIVEN, W_ONES, W_ONES},
        '{KIND_SAR,  P1,     P2,     128,    0,      EXP_GIVEN, W_ONES, W_ONES},
        '{KIND_SAR,  P1,     P2,     64,     0,      EXP_GIVEN, P2,     W_ONES},
        '{KIND_SEXT, W_MSB,  P1,     P2,     P3,     EXP_GIVEN, W_MSB,  W_ONES},
        '{KIND_UNDEF_HI, P1, P2,     P3,     P1,     EXP_GIVEN, 0,      0}
    };

    logic clk;
    logic rst_n;

    i128alu_in_if  req_if ();
    i128alu_out_if rsp_if ();

    int128_alu_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // results still owed by the block, oldest first
    quad_t alu_results_due[$];

    // expectation for the request currently on the bus
    bit    cur_given;
    quad_t cur_want;

    int n_req_xfers;
    int n_rsp_xfers;
    int n_errors;
    int send_calm;

    // 128-bit alu behavior
    function automatic quad_t alu_compute(input kind_bits_t kind, input word_t al,
                                          input word_t ah, input word_t bl, input word_t bh);
        quad_t a;
        quad_t b;
        a = {ah, al};
        b = {bh, bl};
        case (kind)
            KIND_ADD:  return a + b;
            KIND_SUB:  return a - b;
            KIND_NEG:  return -a;
            KIND_MUL:  return a * b;
            KIND_AND:  return a & b;
            KIND_OR:   return a | b;
            KIND_XOR:  return a ^ b;
            KIND_SHL:  return (bl >= QUAD_W) ? '0 : a << bl[SHAMT_W-1:0];
            KIND_SHR:  return (bl >= QUAD_W) ? '0 : a >> bl[SHAMT_W-1:0];
            KIND_SAR:  return (bl >= QUAD_W) ? {QUAD_W{ah[WORD_W-1]}}
                                             : quad_t'($signed(a) >>> bl[SHAMT_W-1:0]);
            KIND_SEXT: return {{WORD_W{al[WORD_W-1]}}, al};
            default:   return '0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_PRINTS)
            $display("tb: mismatch on result %0d: %s", n_rsp_xfers, what);
        n_errors++;
    endtask

    // operand with a bias toward corner values
    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return W_ONES;
            2:       return 64'd1;
            3:       return W_MSB;
            4:       return W_MAXP;
            5:       return word_t'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // shift amount, mostly in range, some at and past the edges
    function automatic word_t pick_shamt();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return word_t'($urandom_range(0, QUAD_W - 1));
        else if (r == 6)
            return '0;
        else if (r == 7)
        begin
            case ($urandom_range(0, 4))
                0:       return 64'd63;
                1:       return 64'd64;
                2:       return 64'd65;
                3:       return 64'd127;
                default: return 64'd128;
            endcase
        end
        else if (r == 8)
            return word_t'($urandom_range(QUAD_W, 300));
        else
            return {$urandom, $urandom};
    endfunction

    // sender idle cycles before the next request
    function automatic int pick_gap();
        int r;
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            send_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // drive one request at a falling edge and wait for its transfer
    task automatic offer_request(input kind_bits_t kind, input word_t al, input word_t ah,
                                 input word_t bl, input word_t bh,
                                 input bit given, input quad_t want);
        int gap;
        int seen;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.kind   <= kind;
        req_if.a_low  <= al;
        req_if.a_high <= ah;
        req_if.b_low  <= bl;
        req_if.b_high <= bh;
        cur_given     <= given;
        cur_want      <= want;
        seen = n_req_xfers;
        do
            @(negedge clk);
        while (n_req_xfers == seen);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request transfers queue expectations, result transfers are checked
    always @(posedge clk)
    begin : watch_xfers
        quad_t want;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                alu_results_due.push_back(cur_given ? cur_want
                    : alu_compute(req_if.kind, req_if.a_low, req_if.a_high,
                                  req_if.b_low, req_if.b_high));
                n_req_xfers++;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (alu_results_due.size() == 0)
                    report_mismatch("result with nothing pending");
                else
                begin
                    want = alu_results_due.pop_front();
                    if (rsp_if.result_low !== want[WORD_W-1:0])
                        report_mismatch($sformatf("result_low %h, want %h",
                                                  rsp_if.result_low, want[WORD_W-1:0]));
                    if (rsp_if.result_high !== want[QUAD_W-1:WORD_W])
                        report_mismatch($sformatf("result_high %h, want %h",
                                                  rsp_if.result_high, want[QUAD_W-1:WORD_W]));
                end
                n_rsp_xfers++;
            end
        end
    end

    // result side backpressure, with one long hold-off to fill the pipe
    initial
    begin : drive_ready
        int  stall_left;
        int  calm_left;
        int  r;
        bit  held_long;
        stall_left = 0;
        calm_left  = 0;
        held_long  = 1'b0;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_long && n_req_xfers >= HOLD_AT_XFER)
            begin
                held_long  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    calm_left = $urandom_range(20, 60);
                    rsp_if.ready <= 1'b1;
                end
                else if (r < 70)
                    rsp_if.ready <= 1'b1;
                else
                begin
                    stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    rsp_if.ready <= 1'b0;
                end
            end
        end
    end

    // reset, directed table, random requests, drain
    initial
    begin : drive_requests
        int         i;
        int         r;
        kind_bits_t kind;
        word_t      al;
        word_t      ah;
        word_t      bl;
        word_t      bh;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.kind   = '0;
        req_if.a_low  = '0;
        req_if.a_high = '0;
        req_if.b_low  = '0;
        req_if.b_high = '0;
        cur_given     = 1'b0;
        cur_want      = '0;
        n_req_xfers   = 0;
        n_rsp_xfers   = 0;
        n_errors      = 0;
        send_calm     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            offer_request(directed_rows[i].kind, directed_rows[i].a_low,
                          directed_rows[i].a_high, directed_rows[i].b_low,
                          directed_rows[i].b_high, directed_rows[i].given,
                          {directed_rows[i].want_high, directed_rows[i].want_low});

        for (i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 99);
            kind = (r < 94) ? kind_bits_t'($urandom_range(KIND_ADD, KIND_SEXT))
                            : kind_bits_t'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
            al = pick_word();
            ah = pick_word();
            bh = pick_word();
            if (kind == KIND_SHL || kind == KIND_SHR || kind == KIND_SAR)
                bl = pick_shamt();
            else
                bl = pick_word();
            offer_request(kind, al, ah, bl, bh, EXP_MODEL, '0);
        end
        req_if.valid <= 1'b0;

        // wait out outstanding results, then keep watching for strays
        while (alu_results_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run time limit
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

// ===== int128_alu_top.f =====
+incdir+hdl
hdl/i128alu_pkg.sv
hdl/i128alu_ifs.sv
hdl/i128alu_basic.sv
hdl/i128alu_mul.sv
hdl/int128_alu_top.sv
dv/tb_int128_alu_top.sv
